// ===== hdl/pmtas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmtas_pkg
// Types and constants shared by the page map table with address split.
// ----------------------------------------------------------------------------
package pmtas_pkg;

	localparam int LPN_W  = 16;
	localparam int PPN_W  = 32;
	localparam int PPB_W  = 11;
	localparam int BPC_W  = 17;
	localparam int CC_W   = 9;
	localparam int CHIP_W = 8;
	localparam int BLK_W  = 16;
	localparam int PIDX_W = 10;

	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PPB = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BPC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CC  = 2'd2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_REMAP  = 1'b1;

	localparam logic [PPB_W-1:0] PPB_RST = 11'd256;
	localparam logic [BPC_W-1:0] BPC_RST = 17'd1024;
	localparam logic [CC_W-1:0]  CC_RST  = 9'd16;

	localparam logic [PPB_W-1:0] PPB_MAX = 11'd1024;
	localparam logic [BPC_W-1:0] BPC_MAX = 17'd65536;
	localparam logic [CC_W-1:0]  CC_MAX  = 9'd256;

	// shared divider: 32-bit dividend, divisor up to 17 bits
	localparam int DIV_NW = 32;
	localparam int DIV_DW = 17;

	typedef struct packed {
		logic              op;
		logic [LPN_W-1:0]  logical_page;
		logic [PPN_W-1:0]  new_physical_page;
	} cmd_t;

	typedef struct packed {
		logic              was_mapped;
		logic [PPN_W-1:0]  physical_page;
		logic [CHIP_W-1:0] chip_index;
		logic [BLK_W-1:0]  block_index;
		logic [PIDX_W-1:0] page_index;
		logic              range_error;
	} result_t;

endpackage

// ===== hdl/pmtas_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmtas_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmtas_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/pmtas_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmtas_div
// Restoring divider, one quotient bit per cycle. done pulses for one cycle
// with quotient and remainder valid; a new start is taken in that cycle.
// ----------------------------------------------------------------------------
module pmtas_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pmtas_pkg::DIV_NW-1:0]  dividend,
	input  logic [pmtas_pkg::DIV_DW-1:0]  divisor,
	output logic                          done,
	output logic [pmtas_pkg::DIV_NW-1:0]  quotient,
	output logic [pmtas_pkg::DIV_DW-1:0]  remainder
);

	localparam int NW = pmtas_pkg::DIV_NW;
	localparam int DW = pmtas_pkg::DIV_DW;
	localparam int CW = $clog2(NW);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			// partial remainder stays below the divisor, so the top bit drops
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/page_map_table_with_address_split_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_map_table_with_address_split_unit
// Logical-to-physical page map. Lookup or remap one logical page per word,
// then split the returned physical page into chip, block and page indices.
// ----------------------------------------------------------------------------
// Timing: an unmapped entry strobes its result after the READ and CHECK states; a mapped entry
//   also runs the shared divider (one bit per cycle) for the page then the block split.
// Flow: one word at a time, no new word before the last result; busy drops in
//   the strobe cycle, and start is taken there. The receiver cannot stall.
// Reset: clears the map to unmapped in a pass over all LOGICAL_PAGES entries with
//   busy high; configuration writes are taken during the pass.
module page_map_table_with_address_split_unit #(
	parameter int LOGICAL_PAGES  = 65536,
	parameter int PHYS_PAGE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  pmtas_pkg::cmd_t                   cmd,
	output logic                              result_valid,
	output pmtas_pkg::result_t                result,
	input  logic                              cfg_we,
	input  logic [pmtas_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pmtas_pkg::CFG_W-1:0]       cfg_data
);

	localparam int AW = $clog2(LOGICAL_PAGES);
	localparam int SW = (PHYS_PAGE_BITS < pmtas_pkg::PPN_W) ? PHYS_PAGE_BITS
	                                                        : pmtas_pkg::PPN_W;
	localparam int MW = SW + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_SPLIT_PAGE,
		ST_SPLIT_BLOCK
	} state_t;

	state_t                           state_q;
	pmtas_pkg::cmd_t                  cmd_q;
	logic                             in_range_q;
	logic [AW-1:0]                    clr_q;
	logic [pmtas_pkg::PPB_W-1:0]      ppb_q;
	logic [pmtas_pkg::BPC_W-1:0]      bpc_q;
	logic [pmtas_pkg::CC_W-1:0]       cc_q;
	pmtas_pkg::result_t               result_q;
	logic                             result_valid_q;

	logic [pmtas_pkg::PPB_W-1:0]      ppb_eff;
	logic [pmtas_pkg::BPC_W-1:0]      bpc_eff;
	logic [pmtas_pkg::CC_W-1:0]       cc_eff;

	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [MW-1:0]                    ram_wdata;
	logic [AW-1:0]                    lpn_addr;
	logic [MW-1:0]                    ram_rdata;
	logic                             mapped;
	logic [SW-1:0]                    old_ppn;

	logic                             div_start;
	logic [pmtas_pkg::DIV_NW-1:0]     div_dividend;
	logic [pmtas_pkg::DIV_DW-1:0]     div_divisor;
	logic                             div_done;
	logic [pmtas_pkg::DIV_NW-1:0]     div_quot;
	logic [pmtas_pkg::DIV_DW-1:0]     div_rem;
	logic                             chip_err;

	// geometry clamps
	always_comb begin
		if (ppb_q == '0) begin
			ppb_eff = pmtas_pkg::PPB_W'(1);
		end else if (ppb_q > pmtas_pkg::PPB_MAX) begin
			ppb_eff = pmtas_pkg::PPB_MAX;
		end else begin
			ppb_eff = ppb_q;
		end
		if (bpc_q == '0) begin
			bpc_eff = pmtas_pkg::BPC_W'(1);
		end else if (bpc_q > pmtas_pkg::BPC_MAX) begin
			bpc_eff = pmtas_pkg::BPC_MAX;
		end else begin
			bpc_eff = bpc_q;
		end
		cc_eff = (cc_q > pmtas_pkg::CC_MAX) ? pmtas_pkg::CC_MAX : cc_q;
	end

	assign lpn_addr  = AW'(cmd_q.logical_page);
	assign mapped    = in_range_q && ram_rdata[SW];
	assign old_ppn   = ram_rdata[SW-1:0];

	assign ram_we    = (state_q == ST_CLEAR) ||
	                   ((state_q == ST_CHECK) && in_range_q &&
	                    (cmd_q.op == pmtas_pkg::OP_REMAP));
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : lpn_addr;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0
	                                         : {1'b1, SW'(cmd_q.new_physical_page)};

	pmtas_ram #(
		.WIDTH (MW),
		.DEPTH (LOGICAL_PAGES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (lpn_addr),
		.rdata (ram_rdata)
	);

	// one divider: page split first, then block split on its quotient
	assign div_start    = ((state_q == ST_CHECK) && mapped) ||
	                      ((state_q == ST_SPLIT_PAGE) && div_done);
	assign div_dividend = (state_q == ST_SPLIT_PAGE) ? div_quot
	                                                 : pmtas_pkg::DIV_NW'(old_ppn);
	assign div_divisor  = (state_q == ST_SPLIT_PAGE) ? bpc_eff
	                                                 : pmtas_pkg::DIV_DW'(ppb_eff);

	pmtas_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign chip_err = div_quot >= pmtas_pkg::DIV_NW'(cc_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			cmd_q          <= '0;
			in_range_q     <= 1'b0;
			ppb_q          <= pmtas_pkg::PPB_RST;
			bpc_q          <= pmtas_pkg::BPC_RST;
			cc_q           <= pmtas_pkg::CC_RST;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					pmtas_pkg::CFG_PPB: ppb_q <= cfg_data[pmtas_pkg::PPB_W-1:0];
					pmtas_pkg::CFG_BPC: bpc_q <= cfg_data[pmtas_pkg::BPC_W-1:0];
					pmtas_pkg::CFG_CC:  cc_q  <= cfg_data[pmtas_pkg::CC_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(LOGICAL_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q      <= cmd;
						in_range_q <= 32'(cmd.logical_page) < 32'(LOGICAL_PAGES);
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (mapped) begin
						result_q.was_mapped    <= 1'b1;
						result_q.physical_page <= pmtas_pkg::PPN_W'(old_ppn);
						state_q                <= ST_SPLIT_PAGE;
					end else begin
						result_q       <= '0;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				ST_SPLIT_PAGE: begin
					if (div_done) begin
						result_q.page_index <= div_rem[pmtas_pkg::PIDX_W-1:0];
						state_q             <= ST_SPLIT_BLOCK;
					end
				end
				ST_SPLIT_BLOCK: begin
					if (div_done) begin
						result_q.chip_index  <= chip_err ? '0
						                                 : div_quot[pmtas_pkg::CHIP_W-1:0];
						result_q.block_index <= div_rem[pmtas_pkg::BLK_W-1:0];
						result_q.range_error <= chip_err;
						result_valid_q       <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== hdl/pmtas_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmtas_check
// Port-level assertions for the page map table, bound to the top level.
// ----------------------------------------------------------------------------
module pmtas_check (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               result_valid,
	input pmtas_pkg::result_t result
);

	// an accepted word keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// results come out of a busy block, one strobe per word
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a word in flight");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.was_mapped |->
			result.physical_page == '0 && result.chip_index == '0 &&
			result.block_index == '0 && result.page_index == '0 &&
			!result.range_error)
		else $error("unmapped result carries nonzero fields");

	a_range_err_chip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.range_error |->
			result.was_mapped && result.chip_index == '0)
		else $error("range error with chip index set");

endmodule

bind page_map_table_with_address_split_unit pmtas_check u_pmtas_check (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the page map table with address split against a predictor of the
// map and the chip/block/page split. Directed words cover unmapped and
// mapped lookups, remaps, range errors and geometry clamping. Random traffic
// then runs over several geometries and sender idle rates. Every result word
// is compared field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [pmtas_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int MAX_PRINTED = 200;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	pmtas_pkg::cmd_t                 cmd;
	logic                            result_valid;
	pmtas_pkg::result_t              result;
	logic                            cfg_we;
	logic [pmtas_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pmtas_pkg::CFG_W-1:0]     cfg_data;

	// shadow copy of the geometry registers and the map
	logic [pmtas_pkg::PPB_W-1:0] ppb_reg;
	logic [pmtas_pkg::BPC_W-1:0] bpc_reg;
	logic [pmtas_pkg::CC_W-1:0]  cc_reg;
	bit                          map_valid [0:(1<<pmtas_pkg::LPN_W)-1];
	bit [pmtas_pkg::PPN_W-1:0]   map_page  [0:(1<<pmtas_pkg::LPN_W)-1];

	pmtas_pkg::result_t pending_translations [$];
	pmtas_pkg::result_t want;
	int                 idle_pct;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;

	page_map_table_with_address_split_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint unsigned eff_ppb();
		if (ppb_reg == 0)
			return 1;
		if (ppb_reg > pmtas_pkg::PPB_MAX)
			return pmtas_pkg::PPB_MAX;
		return ppb_reg;
	endfunction

	function automatic longint unsigned eff_bpc();
		if (bpc_reg == 0)
			return 1;
		if (bpc_reg > pmtas_pkg::BPC_MAX)
			return pmtas_pkg::BPC_MAX;
		return bpc_reg;
	endfunction

	function automatic longint unsigned eff_cc();
		return (cc_reg > pmtas_pkg::CC_MAX) ? pmtas_pkg::CC_MAX : cc_reg;
	endfunction

	// look up or remap one entry and split the page it held
	function automatic pmtas_pkg::result_t translate_page(input logic op,
			input logic [pmtas_pkg::LPN_W-1:0] lpn, input logic [pmtas_pkg::PPN_W-1:0] npn);
		pmtas_pkg::result_t r;
		longint unsigned ppb, bpc, old, blk_all, chip;
		r = '0;
		if (map_valid[lpn]) begin
			ppb = eff_ppb();
			bpc = eff_bpc();
			old = 64'(map_page[lpn]);
			blk_all = old / ppb;
			chip = blk_all / bpc;
			r.was_mapped = 1'b1;
			r.physical_page = pmtas_pkg::PPN_W'(old);
			r.range_error = (chip >= eff_cc());
			r.chip_index = r.range_error ? '0 : pmtas_pkg::CHIP_W'(chip);
			r.block_index = pmtas_pkg::BLK_W'(blk_all % bpc);
			r.page_index = pmtas_pkg::PIDX_W'(old % ppb);
		end
		if (op == pmtas_pkg::OP_REMAP) begin
			map_valid[lpn] = 1'b1;
			map_page[lpn] = npn;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [pmtas_pkg::PPN_W-1:0] got,
			input logic [pmtas_pkg::PPN_W-1:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_translations.size() == 0) begin
				report_mismatch("result word with nothing outstanding");
			end else begin
				want = pending_translations.pop_front();
				check_field("was_mapped", pmtas_pkg::PPN_W'(result.was_mapped),
					pmtas_pkg::PPN_W'(want.was_mapped));
				check_field("physical_page", result.physical_page, want.physical_page);
				check_field("chip_index", pmtas_pkg::PPN_W'(result.chip_index),
					pmtas_pkg::PPN_W'(want.chip_index));
				check_field("block_index", pmtas_pkg::PPN_W'(result.block_index),
					pmtas_pkg::PPN_W'(want.block_index));
				check_field("page_index", pmtas_pkg::PPN_W'(result.page_index),
					pmtas_pkg::PPN_W'(want.page_index));
				check_field("range_error", pmtas_pkg::PPN_W'(result.range_error),
					pmtas_pkg::PPN_W'(want.range_error));
			end
		end
	end

	task automatic send_word(input logic op, input logic [pmtas_pkg::LPN_W-1:0] lpn,
			input logic [pmtas_pkg::PPN_W-1:0] npn);
		pmtas_pkg::cmd_t word;
		word.op = op;
		word.logical_page = lpn;
		word.new_physical_page = npn;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		cmd <= word;
		do @(posedge clk); while (busy);
		pending_translations.push_back(translate_page(op, lpn, npn));
	endtask

	// hold off the sender until the block is idle with nothing outstanding
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_translations.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [pmtas_pkg::CFG_IDX_W-1:0] idx,
			input logic [pmtas_pkg::CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			pmtas_pkg::CFG_PPB: ppb_reg = pmtas_pkg::PPB_W'(data);
			pmtas_pkg::CFG_BPC: bpc_reg = pmtas_pkg::BPC_W'(data);
			pmtas_pkg::CFG_CC:  cc_reg = pmtas_pkg::CC_W'(data);
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_geometry(input logic [pmtas_pkg::CFG_W-1:0] ppb,
			input logic [pmtas_pkg::CFG_W-1:0] bpc, input logic [pmtas_pkg::CFG_W-1:0] cc);
		drain_results();
		cfg_write(pmtas_pkg::CFG_PPB, ppb);
		cfg_write(pmtas_pkg::CFG_BPC, bpc);
		cfg_write(pmtas_pkg::CFG_CC, cc);
		cfg_release();
	endtask

	function automatic logic [pmtas_pkg::PPN_W-1:0] pick_page();
		longint unsigned span;
		span = eff_ppb() * eff_bpc() * (eff_cc() + 1);
		if (span > 64'hFFFF_FFFF)
			span = 64'hFFFF_FFFF;
		if ($urandom_range(3) == 0)
			return $urandom();
		return $urandom_range(32'(span - 1), 0);
	endfunction

	// reset geometry: 256 pages, 1024 blocks, 16 chips
	task automatic test_default_geometry();
		send_word(pmtas_pkg::OP_LOOKUP, '0, '1);
		send_word(pmtas_pkg::OP_LOOKUP, '1, '0);
		send_word(pmtas_pkg::OP_REMAP, '0, '0);
		send_word(pmtas_pkg::OP_LOOKUP, '0, '0);
		send_word(pmtas_pkg::OP_REMAP, '1, '1);
		send_word(pmtas_pkg::OP_LOOKUP, '1, '0);
		send_word(pmtas_pkg::OP_REMAP, '0, 32'h03FF_FFFF);
		send_word(pmtas_pkg::OP_LOOKUP, '0, '0);
		send_word(pmtas_pkg::OP_REMAP, '0, 32'h0400_0000);
		send_word(pmtas_pkg::OP_LOOKUP, '0, '0);
	endtask

	task automatic test_geometry_clamps();
		// zero chips: every mapped page is out of range
		set_geometry('0, '0, '0);
		send_word(pmtas_pkg::OP_LOOKUP, '0, '0);
		send_word(pmtas_pkg::OP_LOOKUP, '1, '0);
		set_geometry(17'd2047, 17'd131071, 17'd511);
		send_word(pmtas_pkg::OP_LOOKUP, '1, '0);
		send_word(pmtas_pkg::OP_REMAP, '1, '0);
		// one page per block, one block per chip: chip index is the page while below 256
		set_geometry(17'd1, 17'd1, 17'd256);
		send_word(pmtas_pkg::OP_REMAP, 16'd1, 32'd255);
		send_word(pmtas_pkg::OP_LOOKUP, 16'd1, '0);
		send_word(pmtas_pkg::OP_REMAP, 16'd1, 32'd256);
		send_word(pmtas_pkg::OP_LOOKUP, 16'd1, '0);
	endtask

	task automatic test_config_masking();
		drain_results();
		cfg_write(pmtas_pkg::CFG_PPB, '1);
		cfg_write(pmtas_pkg::CFG_BPC, '1);
		cfg_write(pmtas_pkg::CFG_CC, '1);
		cfg_write(CFG_UNUSED, 17'd1);
		cfg_release();
		send_word(pmtas_pkg::OP_LOOKUP, '1, '0);
		send_word(pmtas_pkg::OP_LOOKUP, '0, '0);
		send_word(pmtas_pkg::OP_LOOKUP, 16'd1, '0);
	endtask

	task automatic test_random_traffic(input int sender_idle);
		logic [pmtas_pkg::LPN_W-1:0] hot_pages [16];
		logic [pmtas_pkg::LPN_W-1:0] lpn;
		idle_pct = sender_idle;
		foreach (hot_pages[i])
			hot_pages[i] = pmtas_pkg::LPN_W'($urandom_range(65535));
		hot_pages[0] = '0;
		hot_pages[1] = '1;
		for (int set_idx = 0; set_idx < 4; set_idx++) begin
			// small geometries or the full register range, chosen at equal odds
			if ($urandom_range(1))
				set_geometry(pmtas_pkg::CFG_W'($urandom_range(64, 1)),
					pmtas_pkg::CFG_W'($urandom_range(256, 1)),
					pmtas_pkg::CFG_W'($urandom_range(16, 1)));
			else
				set_geometry(pmtas_pkg::CFG_W'($urandom_range(2047)),
					pmtas_pkg::CFG_W'($urandom_range(131071)),
					pmtas_pkg::CFG_W'($urandom_range(511)));
			for (int n = 0; n < 67; n++) begin
				lpn = ($urandom_range(3) != 0) ? hot_pages[$urandom_range(15)]
				                               : pmtas_pkg::LPN_W'($urandom());
				send_word(($urandom_range(1) == 1) ? pmtas_pkg::OP_REMAP : pmtas_pkg::OP_LOOKUP,
					lpn, pick_page());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ppb_reg = pmtas_pkg::PPB_RST;
		bpc_reg = pmtas_pkg::BPC_RST;
		cc_reg = pmtas_pkg::CC_RST;
		idle_pct = 19;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_geometry();
		test_geometry_clamps();
		test_config_masking();
		test_random_traffic(19);
		test_random_traffic(87);
		test_random_traffic(0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_translations.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/pmtas_pkg.sv
hdl/pmtas_ram.sv
hdl/pmtas_div.sv
hdl/page_map_table_with_address_split_unit.sv
hdl/pmtas_check.sv
verif/testbench.sv
